/* rtl/core/kmhid_pkg.sv */
// Shared types and constants of the key matrix to HID report block.
package kmhid_pkg;

  localparam int ROWS        = 9;
  localparam int COLUMNS     = 8;
  localparam int LAYERS      = 2;
  localparam int MAX_KEYS    = 6;
  localparam int TABLES      = 4;
  localparam int SLOTS       = 6;
  localparam int ENTRY_W     = 8;

  localparam int NPOS        = ROWS * COLUMNS;
  localparam int POS_W       = $clog2(NPOS);
  localparam int PCNT_W      = $clog2(NPOS + 1);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int STORE_DEPTH = LAYERS * NPOS;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = 3;
  localparam int SLOT_W      = $clog2(SLOTS);

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic [3:0] FN_ROW_RST    = 4'd1;
  localparam logic [2:0] FN_COLUMN_RST = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FN_ROW    = 4'd0,
    REG_FN_COLUMN = 4'd1
  } reg_idx_e;

  typedef enum logic {
    KIND_SCAN = 1'b0,
    KIND_LOAD = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    TBL_KEYS     = 2'd0,
    TBL_MODIFIER = 2'd1,
    TBL_MOUSE    = 2'd2,
    TBL_CONSUMER = 2'd3
  } table_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [63:0] matrix_rows_low;
    logic [7:0]  matrix_row_last;
    logic [1:0]  table_select;
    logic        load_layer;
    logic [3:0]  load_row;
    logic [2:0]  load_column;
    logic [7:0]  entry_value;
  } scan_word_t;

  typedef struct packed {
    logic [2:0] key_count;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic [7:0] modifier_bits;
    logic [7:0] mouse_buttons;
    logic [7:0] consumer_usage;
    logic       fn_active;
    logic [3:0] change_flags;
  } report_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_word_t;

endpackage

/* rtl/core/kmhid_if.sv */
// Handshake channels of the key matrix to HID report block.
interface kmhid_scan_if;
  import kmhid_pkg::*;
  logic       valid;
  logic       ready;
  scan_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmhid_report_if;
  import kmhid_pkg::*;
  logic         valid;
  logic         ready;
  report_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kmhid_cfg_if;
  import kmhid_pkg::*;
  logic      valid;
  logic      ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/kmhid_ram.sv */
// Generic single-port-write RAM with registered read.
module kmhid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/key_matrix_to_hid_report_core.sv */
// Scan walker: one matrix snapshot per item, one key position per cycle.
// A scan is accepted in idle, walks NPOS (72) positions through the keymap RAMs,
// and registers its report in the result step, which a held report blocks; only
// then does the walker return to idle and take a new item.
// A keymap load is written into the selected table as it is accepted.
// After reset all STORE_DEPTH (144) keymap RAM entries are swept to zero,
// during which no item is accepted; configuration writes are taken throughout.
module key_matrix_to_hid_report_core
  import kmhid_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  kmhid_scan_if.sink       scan_in,
  kmhid_report_if.source   rep_out,
  kmhid_cfg_if.sink        cfg_wr
);

  state_e state_q, state_d;

  logic [3:0]          fn_row_q;
  logic [2:0]          fn_col_q;
  logic [STORE_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [PCNT_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]    rd_pos_q;
  logic                rd_vld_q, rd_vld_d;
  logic                layer_q;
  logic [NPOS-1:0]     matrix_q;

  logic                keys_done_q, keys_done_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [ENTRY_W-1:0]  slots_q [SLOTS];
  logic [ENTRY_W-1:0]  slots_d [SLOTS];
  logic [ENTRY_W-1:0]  mods_q, mods_d, mouse_q, mouse_d, cons_q, cons_d;
  logic [TABLES-1:0]   chg_q, chg_d;
  logic [COLUMNS-1:0]  prev_q [TABLES][ROWS];
  logic [COLUMNS-1:0]  prev_d [TABLES][ROWS];

  logic                out_valid_q, out_valid_d;
  report_word_t        out_data_q, out_data_d;

  logic                in_accept, scan_start, load_write, load_in_range;
  logic [NPOS-1:0]     in_matrix;
  logic [POS_W-1:0]    fn_idx;
  logic                fn_hit;

  logic [TABLES-1:0]   ram_we;
  logic [STORE_AW-1:0] ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata [TABLES];

  logic [ROW_W-1:0]    rd_row;
  logic [COL_W-1:0]    rd_col;
  logic                now_bit;
  logic [COLUMNS-1:0]  now_row;

  // ---------------------------------------------------------------- input side
  assign scan_in.ready = (state_q == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign in_accept     = scan_in.valid && scan_in.ready;
  assign scan_start    = in_accept && (scan_in.data.kind == KIND_SCAN);
  assign load_in_range = (scan_in.data.load_row < 4'(ROWS));
  assign load_write    = in_accept && (scan_in.data.kind == KIND_LOAD) && load_in_range;

  assign in_matrix = NPOS'({scan_in.data.matrix_row_last, scan_in.data.matrix_rows_low});
  assign fn_idx    = POS_W'({fn_row_q, fn_col_q});
  assign fn_hit    = (fn_row_q < 4'(ROWS)) && in_matrix[fn_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_row_q <= FN_ROW_RST;
      fn_col_q <= FN_COLUMN_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.data.index)
        REG_FN_ROW:    fn_row_q <= cfg_wr.data.value[3:0];
        REG_FN_COLUMN: fn_col_q <= cfg_wr.data.value[2:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- keymap RAMs
  always_comb begin
    ram_we    = '0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (state_q == ST_CLEAR) begin
      ram_we = '1;
    end else if (load_write) begin
      ram_we[scan_in.data.table_select] = 1'b1;
      ram_waddr = STORE_AW'({scan_in.data.load_row, scan_in.data.load_column})
                + (scan_in.data.load_layer ? STORE_AW'(NPOS) : '0);
      ram_wdata = scan_in.data.entry_value;
    end
  end

  assign ram_raddr = STORE_AW'(pos_q[POS_W-1:0]) + (layer_q ? STORE_AW'(NPOS) : '0);

  for (genvar t = 0; t < TABLES; t++) begin : g_ram
    kmhid_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[t]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[t])
    );
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_cnt_q == STORE_AW'(STORE_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (scan_start) state_d = ST_WALK;
      ST_WALK:   if (pos_q == PCNT_W'(NPOS)) state_d = ST_RESULT;
      ST_RESULT: if (!out_valid_q || rep_out.ready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    pos_d     = pos_q;
    rd_vld_d  = 1'b0;
    case (state_q)
      ST_CLEAR: clr_cnt_d = clr_cnt_q + 1'b1;
      ST_IDLE:  pos_d = '0;
      ST_WALK: begin
        rd_vld_d = (pos_q < PCNT_W'(NPOS));
        if (rd_vld_d) pos_d = pos_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      pos_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pos_q     <= pos_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= pos_q[POS_W-1:0];
    if (scan_start) begin
      matrix_q <= in_matrix;
      layer_q  <= fn_hit;
    end
  end

  // ---------------------------------------------------------------- position unit
  assign rd_row  = rd_pos_q[POS_W-1:COL_W];
  assign rd_col  = rd_pos_q[COL_W-1:0];
  assign now_bit = matrix_q[rd_pos_q];
  assign now_row = matrix_q[rd_row*COLUMNS +: COLUMNS];

  always_comb begin
    logic [TABLES-1:0] mapped;
    logic [TABLES-1:0] differs;
    keys_done_d = keys_done_q;
    count_d     = count_q;
    slots_d     = slots_q;
    mods_d      = mods_q;
    mouse_d     = mouse_q;
    cons_d      = cons_q;
    chg_d       = chg_q;
    prev_d      = prev_q;
    for (int t = 0; t < TABLES; t++) begin
      mapped[t]  = (ram_rdata[t] != '0);
      differs[t] = now_bit ^ prev_q[t][rd_row][rd_col];
    end
    if (scan_start) begin
      keys_done_d = 1'b0;
      count_d     = '0;
      for (int k = 0; k < SLOTS; k++) slots_d[k] = '0;
      mods_d      = '0;
      mouse_d     = '0;
      cons_d      = '0;
      chg_d       = '0;
    end else if (rd_vld_q) begin
      // key table stops looking once the report is full
      if (!keys_done_q && mapped[TBL_KEYS]) begin
        if (differs[TBL_KEYS]) chg_d[TBL_KEYS] = 1'b1;
        if (now_bit) begin
          if (count_q < COUNT_W'(SLOTS)) slots_d[count_q[SLOT_W-1:0]] = ram_rdata[TBL_KEYS];
          count_d = count_q + 1'b1;
          if (count_d >= COUNT_W'(MAX_KEYS)) keys_done_d = 1'b1;
        end
      end
      if (mapped[TBL_MODIFIER]) begin
        if (differs[TBL_MODIFIER]) chg_d[TBL_MODIFIER] = 1'b1;
        if (now_bit) mods_d = mods_q | ram_rdata[TBL_MODIFIER];
      end
      if (mapped[TBL_MOUSE]) begin
        if (differs[TBL_MOUSE]) chg_d[TBL_MOUSE] = 1'b1;
        if (now_bit) mouse_d = mouse_q | ram_rdata[TBL_MOUSE];
      end
      if (mapped[TBL_CONSUMER]) begin
        if (differs[TBL_CONSUMER]) chg_d[TBL_CONSUMER] = 1'b1;
        if (now_bit) cons_d = ram_rdata[TBL_CONSUMER];
      end
      // end of row: store the snapshot, except the key row once the report is full
      if (rd_col == COL_W'(COLUMNS - 1)) begin
        if (!keys_done_d) prev_d[TBL_KEYS][rd_row] = now_row;
        prev_d[TBL_MODIFIER][rd_row] = now_row;
        prev_d[TBL_MOUSE][rd_row]    = now_row;
        prev_d[TBL_CONSUMER][rd_row] = now_row;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    keys_done_q <= keys_done_d;
    count_q     <= count_d;
    slots_q     <= slots_d;
    mods_q      <= mods_d;
    mouse_q     <= mouse_d;
    cons_q      <= cons_d;
    chg_q       <= chg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TABLES; t++) begin
        for (int r = 0; r < ROWS; r++) prev_q[t][r] <= '0;
      end
    end else begin
      prev_q <= prev_d;
    end
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && rep_out.ready) out_valid_d = 1'b0;
    if (state_q == ST_RESULT && (!out_valid_q || rep_out.ready)) begin
      out_valid_d               = 1'b1;
      out_data_d.key_count      = count_q;
      out_data_d.key_slot_0     = slots_q[0];
      out_data_d.key_slot_1     = slots_q[1];
      out_data_d.key_slot_2     = slots_q[2];
      out_data_d.key_slot_3     = slots_q[3];
      out_data_d.key_slot_4     = slots_q[4];
      out_data_d.key_slot_5     = slots_q[5];
      out_data_d.modifier_bits  = mods_q;
      out_data_d.mouse_buttons  = mouse_q;
      out_data_d.consumer_usage = cons_q;
      out_data_d.fn_active      = layer_q;
      out_data_d.change_flags   = chg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign rep_out.valid = out_valid_q;
  assign rep_out.data  = out_data_q;

`ifndef ASSERT_OFF
  a_rd_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == ST_WALK))
    else $error("position processed outside the walk");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESULT) |-> (count_q <= COUNT_W'(MAX_KEYS)))
    else $error("key count beyond the report limit");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && pos_q == PCNT_W'(NPOS)) |-> rd_vld_q)
    else $error("last position not in flight at walk end");

  a_report_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("report word raised outside the result step");
`endif

endmodule
